// ===== design/segment_reassembly_tracker_core_defines.svh =====
// Assertion macros shared by the reassembly tracker modules.
// Depends on nothing; included by modules that assert.
`ifndef SEGMENT_REASSEMBLY_TRACKER_CORE_DEFINES_SVH
`define SEGMENT_REASSEMBLY_TRACKER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/srt_pkg.sv =====
// Shared types and constants of the segment reassembly tracker.
// No dependencies.
package srt_pkg;
  localparam int unsigned SegBytes = 12;
  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_COMPLETED = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_OLD       = 3'd3;
  localparam logic [2:0] ST_NO_SLOT   = 3'd4;
  localparam logic [2:0] ST_LEN_BAD   = 3'd5;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input word, start lookup
    logic decide;    // apply slot update and build result
    logic wr_byte;   // write one payload byte
  } srt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       do_write;   // segment has bytes to store
    logic [3:0] wr_count;   // number of bytes to store
  } srt_stat_t;
endpackage

// ===== design/srt_ctrl.sv =====
// Controller of the segment reassembly tracker: sequences lookup, byte
// writes and result hand-off. Depends on srt_pkg and the core defines header.
`include "segment_reassembly_tracker_core_defines.svh"
module srt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output srt_pkg::srt_cmd_t cmd,
  input  srt_pkg::srt_stat_t stat,
  output logic [3:0]        byte_idx
);
  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_DECIDE, S_CHECK, S_WRITE, S_OUT} state_t;
  state_t     state;
  logic [3:0] cnt;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_valid = (state == S_OUT);
  assign byte_idx  = cnt;
  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.decide  = (state == S_DECIDE);
    cmd.wr_byte = (state == S_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_LOOK;
        S_LOOK:   state <= S_DECIDE;
        S_DECIDE: state <= S_CHECK;
        S_CHECK: begin
          cnt <= '0;
          state <= (stat.do_write && stat.wr_count != 4'd0) ? S_WRITE : S_OUT;
        end
        S_WRITE: begin
          cnt <= cnt + 4'd1;
          if (cnt + 4'd1 >= stat.wr_count) state <= S_OUT;
        end
        S_OUT:    if (out_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  `SRT_ASSERT_IMP(a_ready_idle, in_ready, !out_valid, "ready while result pending")
  `SRT_ASSERT_NXT(a_load_look, cmd.load, state == S_LOOK, "load did not start lookup")
  `SRT_ASSERT_IMP(a_wr_bound, cmd.wr_byte, cnt < stat.wr_count, "byte write past count")
endmodule

// ===== design/srt_dp.sv =====
// Datapath of the segment reassembly tracker: slot table, SeqAuth compare,
// payload memory and result register. Depends on srt_pkg.
module srt_dp #(
  parameter int unsigned SLOTS = 4,
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  srt_pkg::srt_cmd_t  cmd,
  output srt_pkg::srt_stat_t stat,
  input  logic [3:0]         byte_idx,
  input  logic [191:0]       in_word,
  output logic [20:0]        out_word
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DEPTH = SLOTS * MAX_SEGMENTS * srt_pkg::SegBytes;
  localparam int unsigned AW = $clog2(DEPTH);

  logic [SLOTS-1:0] busy, armed;
  logic [15:0] src_t [SLOTS];
  logic [55:0] auth_t [SLOTS];
  logic [4:0]  last_t [SLOTS];
  logic [31:0] mask_t [SLOTS];
  logic [7:0]  mem [DEPTH];

  logic [15:0] src; logic [55:0] auth; logic [4:0] segn, sego;
  logic [3:0] nb; logic [95:0] pay; logic [6:0] ttl;
  // lookup results, registered
  logic hit, fre; logic [SW-1:0] hs, fs;
  logic [SW-1:0] ws; logic [4:0] wseg;
  logic [3:0] wcnt; logic dow;
  logic [20:0] res;

  assign stat.do_write = dow;
  assign stat.wr_count = wcnt;
  assign out_word = res;

  logic c_hit, c_fre; logic [SW-1:0] c_hs, c_fs;
  always_comb begin
    c_hit = 1'b0; c_fre = 1'b0; c_hs = '0; c_fs = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (busy[i] && src_t[i] == src) begin c_hit = 1'b1; c_hs = SW'(i); end
      if (!busy[i]) begin c_fre = 1'b1; c_fs = SW'(i); end
    end
  end

  function automatic logic [31:0] mask_upto(input logic [4:0] l);
    mask_upto = (l == 5'd31) ? 32'hFFFF_FFFF : ((32'd1 << (l + 5'd1)) - 32'd1);
  endfunction

  logic [12:0] delay;
  assign delay = 13'd150 + 13'(ttl) * 13'd50;

  always_ff @(posedge clk) begin
    if (cmd.wr_byte)
      mem[AW'((32'(ws) * MAX_SEGMENTS + 32'(wseg)) * srt_pkg::SegBytes + 32'(byte_idx))]
        <= pay[8'd95 - 8'(byte_idx) * 8'd8 -: 8];
  end

  always_ff @(posedge clk) begin
    logic [SW-1:0] s; logic [31:0] m; logic [2:0] st; logic dn, ak, ic;
    logic w, fresh, ar;
    logic [3:0] cnt;
    hit <= c_hit; fre <= c_fre; hs <= c_hs; fs <= c_fs;
    if (rst) begin
      busy <= '0; armed <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        src_t[i] <= '0; auth_t[i] <= '0; last_t[i] <= '0; mask_t[i] <= '0;
      end
      dow <= 1'b0;
    end else if (cmd.load) begin
      src <= in_word[15:0];
      // SeqAuth is the IV index above the 24-bit sequence origin
      auth <= {in_word[47:16], in_word[71:48]};
      segn <= in_word[76:72]; sego <= in_word[81:77];
      nb <= in_word[85:82]; pay <= {in_word[117:86], in_word[181:118]};
      ttl <= in_word[188:182];
      dow <= 1'b0;
    end else if (cmd.decide) begin
      st = srt_pkg::ST_STORED; dn = 1'b0; ak = 1'b0; ic = 1'b0; w = 1'b0;
      s = '0; m = '0; fresh = 1'b0; ar = 1'b0;
      cnt = (nb > 4'd12) ? 4'd12 : nb;
      if (32'(segn) >= MAX_SEGMENTS) st = srt_pkg::ST_LEN_BAD;
      else if (hit && auth < auth_t[hs]) st = srt_pkg::ST_OLD;
      else if (!hit && !fre) st = srt_pkg::ST_NO_SLOT;
      else begin
        s = hit ? hs : fs;
        // a new source or a newer SeqAuth opens the slot afresh
        fresh = !hit || auth > auth_t[s];
        m = fresh ? mask_upto(segn) : mask_t[s];
        ar = fresh ? 1'b0 : armed[s];
        if ((!fresh && last_t[s] != segn) || sego > segn) st = srt_pkg::ST_LEN_BAD;
        else if (m == '0) begin st = srt_pkg::ST_ALREADY; dn = 1'b1; end
        else begin
          m = m & ~(32'd1 << sego);
          if (segn == 5'd0) m = '0;
          w = 1'b1;
          if (m == '0) begin
            st = srt_pkg::ST_COMPLETED; dn = 1'b1; ar = 1'b0;
          end else begin
            ic = 1'b1;
            if (!ar) begin ar = 1'b1; ak = 1'b1; end
          end
        end
        if (fresh) begin
          busy[s] <= 1'b1; src_t[s] <= src; auth_t[s] <= auth; last_t[s] <= segn;
        end
        mask_t[s] <= m; armed[s] <= ar;
      end
      dow <= w; ws <= s; wseg <= sego;
      wcnt <= (sego == segn) ? cnt : 4'd12;
      res <= {ic, delay, ak, dn, 2'(s), st};
    end
  end
endmodule

// ===== design/segment_reassembly_tracker_core.sv =====
// Segment reassembly tracker: one received segment in, one status word out.
// The status word is valid after the lookup, decide and check states and a
// write state for each stored payload byte (up to 12). One segment at a
// time: the next word is taken only after the status word has left. Reset
// clears all slot state; payload memory is left as is and never read.
module segment_reassembly_tracker_core #(
  parameter int unsigned SLOTS = 4,
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // source_addr, net_iv, seq_start, last_seg_number, seg_offset,
  // seg_bytes, payload_head, payload_tail, hop_ttl (low bit up)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, slot_index, all_received, start_ack_timer, ack_delay_ms,
  // restart_incomplete (low bit up)
  output logic [23:0]  m_axis_tdata
);
  srt_pkg::srt_cmd_t  cmd;
  srt_pkg::srt_stat_t stat;
  logic [3:0]  byte_idx;
  logic [20:0] res;

  // Sequence one word through lookup, decide, byte writes and hand-off.
  srt_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd, .stat, .byte_idx
  );

  // Hold slot table and payload memory.
  srt_dp #(.SLOTS(SLOTS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk, .rst, .cmd, .stat, .byte_idx, .in_word(s_axis_tdata), .out_word(res)
  );

  assign m_axis_tdata = {3'd0, res};
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for segment_reassembly_tracker_core: drives received segments on the
// input stream and checks every status word against a built-in slot tracker model.
// Depends on srt_pkg and the RTL of segment_reassembly_tracker_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 4;
  localparam int NSEG = 32;
  localparam int RANDOM_WORDS = 1950;

  typedef struct packed {
    logic [6:0]  hop_ttl;
    logic [63:0] payload_tail;
    logic [31:0] payload_head;
    logic [3:0]  seg_bytes;
    logic [4:0]  seg_offset;
    logic [4:0]  last_seg_number;
    logic [23:0] seq_start;
    logic [31:0] net_iv;
    logic [15:0] source_addr;
  } segment_t;

  typedef struct packed {
    logic        restart_incomplete;
    logic [12:0] ack_delay_ms;
    logic        start_ack_timer;
    logic        all_received;
    logic [1:0]  slot_index;
    logic [2:0]  status;
  } verdict_t;

  // Scoreboard: tracks slot state and holds the verdicts still owed by the block.
  class reassembly_scoreboard;
    bit          busy[NSLOT];
    logic [15:0] src[NSLOT];
    logic [55:0] auth[NSLOT];
    logic [4:0]  last[NSLOT];
    logic [31:0] missing[NSLOT];
    bit          armed[NSLOT];
    verdict_t    owed[$];
    int          errors;

    function void clear();
      for (int i = 0; i < NSLOT; i++) begin
        busy[i] = 0; src[i] = '0; auth[i] = '0; last[i] = '0;
        missing[i] = '0; armed[i] = 0;
      end
      owed.delete();
      errors = 0;
    endfunction

    function void open(int s, logic [15:0] a, logic [55:0] sa, logic [4:0] n);
      busy[s] = 1; src[s] = a; auth[s] = sa; last[s] = n;
      missing[s] = (n == 31) ? 32'hFFFF_FFFF : ((32'd1 << (n + 1)) - 1);
      armed[s] = 0;
    endfunction

    function void note_segment(segment_t g);
      verdict_t v;
      logic [55:0] sa;
      int hit, s;
      v = '0;
      v.ack_delay_ms = 13'(150 + 50 * g.hop_ttl);
      sa = {g.net_iv, 24'd0} + 56'(g.seq_start);
      hit = -1;
      for (int i = 0; i < NSLOT; i++)
        if (hit < 0 && busy[i] && src[i] == g.source_addr) hit = i;
      if (hit >= 0) begin
        s = hit;
        if (sa > auth[s]) open(s, g.source_addr, sa, g.last_seg_number);
        else if (sa < auth[s]) begin
          v.status = srt_pkg::ST_OLD; owed.push_back(v); return;
        end
      end else begin
        for (int i = 0; i < NSLOT; i++) if (hit < 0 && !busy[i]) hit = i;
        if (hit < 0) begin
          v.status = srt_pkg::ST_NO_SLOT; owed.push_back(v); return;
        end
        s = hit;
        open(s, g.source_addr, sa, g.last_seg_number);
      end
      v.slot_index = 2'(s);
      if (last[s] != g.last_seg_number || g.seg_offset > g.last_seg_number)
        v.status = srt_pkg::ST_LEN_BAD;
      else if (missing[s] == 0) begin
        v.status = srt_pkg::ST_ALREADY; v.all_received = 1;
      end else begin
        missing[s][g.seg_offset] = 1'b0;
        if (missing[s] == 0) begin
          armed[s] = 0; v.status = srt_pkg::ST_COMPLETED; v.all_received = 1;
        end else begin
          if (!armed[s]) begin
            armed[s] = 1; v.start_ack_timer = 1;
          end
          v.restart_incomplete = 1; v.status = srt_pkg::ST_STORED;
        end
      end
      owed.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t e;
      if (owed.size() == 0) begin
        $error("status word with nothing expected: %h", got); errors++; return;
      end
      e = owed.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++; end
      if (got.slot_index !== e.slot_index) begin
        $error("slot_index exp %0d got %0d", e.slot_index, got.slot_index); errors++; end
      if (got.all_received !== e.all_received) begin
        $error("all_received exp %0d got %0d", e.all_received, got.all_received);
        errors++; end
      if (got.start_ack_timer !== e.start_ack_timer) begin
        $error("start_ack_timer exp %0d got %0d", e.start_ack_timer,
               got.start_ack_timer); errors++; end
      if (got.ack_delay_ms !== e.ack_delay_ms) begin
        $error("ack_delay_ms exp %0d got %0d", e.ack_delay_ms, got.ack_delay_ms);
        errors++; end
      if (got.restart_incomplete !== e.restart_incomplete) begin
        $error("restart_incomplete exp %0d got %0d", e.restart_incomplete,
               got.restart_incomplete); errors++; end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [23:0]  m_axis_tdata;

  reassembly_scoreboard sb = new();
  bit hold_off = 0;        // set by the stimulus to request a long output stall
  int words_sent = 0;

  always #1 clk = ~clk;

  segment_reassembly_tracker_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Sample on the rising edge: note accepted segments, check status words.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_segment(segment_t'(s_axis_tdata[188:0]));
      if (m_axis_tvalid && m_axis_tready) sb.check_verdict(verdict_t'(m_axis_tdata[20:0]));
    end
  end

  // Receiver: own stall pattern, long hold-off on request, no stalls in some stretches.
  initial begin
    int mode;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
        @(negedge clk);
      end
    end
  end

  int burst_left = 0;

  // Offer one segment at the falling edge and hold it until it is accepted.
  task automatic send_word(segment_t g);
    if (burst_left == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid = 1;
    s_axis_tdata = {3'd0, g};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 0;
    words_sent++;
  endtask

  task automatic drain();
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic segment_t rand_segment();
    segment_t g;
    logic [191:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    g = r[188:0];
    g.seg_bytes = 4'($urandom_range(0, 15));
    return g;
  endfunction

  function automatic segment_t make(logic [15:0] a, logic [31:0] iv, logic [23:0] sq,
                                    logic [4:0] n, logic [4:0] o);
    segment_t g;
    g = rand_segment();
    g.source_addr = a; g.net_iv = iv; g.seq_start = sq;
    g.last_seg_number = n; g.seg_offset = o;
    if ($urandom_range(0, 1)) g.seg_bytes = 4'($urandom_range(1, 12));
    return g;
  endfunction

  // Small source pool so sources meet their slots again; a whole message at a time.
  task automatic send_message(logic [15:0] a, logic [31:0] iv, logic [23:0] sq,
                              logic [4:0] n);
    int order[$];
    segment_t g;
    for (int i = 0; i <= n; i++) order.push_back(i);
    order.shuffle();
    foreach (order[i]) begin
      g = make(a, iv, sq, n, 5'(order[i]));
      if ($urandom_range(0, 15) == 0) g.seg_offset = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 20) == 0) g.last_seg_number = 5'($urandom_range(0, 31));
      send_word(g);
      if ($urandom_range(0, 10) == 0) send_word(g);
    end
  endtask

  initial begin
    segment_t g;
    logic [15:0] a;
    sb.clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, single segment, duplicate, restart, old, no slot, bad length.
    send_word(make(16'h0000, 32'h0, 24'h0, 5'd0, 5'd0));
    send_word(make(16'h0000, 32'h0, 24'h0, 5'd0, 5'd0));
    g = make(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 5'd31, 5'd31);
    g.hop_ttl = 7'h7F; g.seg_bytes = 4'hF;
    g.payload_head = '1; g.payload_tail = '1;
    send_word(g);
    send_word(make(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 5'd31, 5'd0));
    send_word(make(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 5'd31, 5'd0));
    send_word(make(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFE, 5'd31, 5'd1));
    send_word(make(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 5'd30, 5'd1));
    send_word(make(16'h1234, 32'h5, 24'h10, 5'd2, 5'd0));
    send_word(make(16'h1234, 32'h5, 24'h10, 5'd2, 5'd3));
    send_word(make(16'h1234, 32'h5, 24'h11, 5'd1, 5'd1));
    send_word(make(16'h1234, 32'h5, 24'h11, 5'd1, 5'd0));
    send_word(make(16'h1234, 32'h5, 24'h11, 5'd1, 5'd0));
    send_word(make(16'h4321, 32'h1, 24'h0, 5'd3, 5'd2));
    send_word(make(16'h5555, 32'h1, 24'h0, 5'd3, 5'd2));
    send_word(make(16'hAAAA, 32'h1, 24'h0, 5'd3, 5'd2));
    g = make(16'h0001, 32'h0, 24'h0, 5'd0, 5'd0);
    g.hop_ttl = 0; g.seg_bytes = 0; g.payload_head = '0; g.payload_tail = '0;
    send_word(g);
    drain();

    // Long output stall while segments keep coming so the input backs up.
    hold_off = 1;
    for (int i = 0; i < 12; i++) send_word(rand_segment());
    drain();

    while (words_sent < RANDOM_WORDS) begin
      a = 16'($urandom_range(0, 6));
      if ($urandom_range(0, 7) == 0) begin
        send_word(rand_segment());
      end else begin
        send_message(a, 32'($urandom_range(0, 2)), 24'($urandom_range(0, 3)),
                     5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 5)));
      end
    end

    drain();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
